@@ design/fmpm_pkg.sv @@
// Shared types, constants and modular add/subtract helpers for the
// Fibonacci matrix power unit. No dependencies.
`timescale 1ns / 1ps

package fmpm_pkg;

  localparam int unsigned MOD_W    = 30;   // residue / modulus width
  localparam int unsigned IDX_W    = 63;   // query index width
  localparam int unsigned CNT_W    = 6;    // holds a bit count up to IDX_W
  localparam int unsigned PROD_NUM = 4;    // products per matrix multiply
  localparam int unsigned PIDX_W   = 2;

  localparam logic [MOD_W-1:0] MOD_RESET = 30'd1000000007;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NMOD_GO,
    S_NMOD_WAIT,
    S_BIT,
    S_MUL_GO,
    S_MUL_WAIT,
    S_ADD_A,
    S_ADD_B,
    S_SUB_C,
    S_DONE
  } fmpm_state_e;

  // Symmetric Fibonacci power [[a, b], [b, c]]
  typedef struct packed {
    logic [MOD_W-1:0] a;
    logic [MOD_W-1:0] b;
    logic [MOD_W-1:0] c;
  } fmpm_mat_t;

  typedef struct packed {
    logic             start;
    logic [IDX_W-1:0] opd;    // multiplier operand, MSB aligned
    logic [CNT_W-1:0] len;    // number of operand bits to scan
    logic [MOD_W-1:0] mult;   // multiplicand, below the modulus
  } fmpm_mul_req_t;

  typedef struct packed {
    logic             done;
    logic [MOD_W-1:0] prod;
  } fmpm_mul_rsp_t;

  typedef struct packed {
    logic [MOD_W-1:0] fib;
    logic [MOD_W-1:0] nmod;
  } fmpm_res_t;

  // (a + b) mod p for a, b < p
  function automatic logic [MOD_W-1:0] mod_add(input logic [MOD_W-1:0] a,
                                               input logic [MOD_W-1:0] b,
                                               input logic [MOD_W-1:0] p);
    logic [MOD_W:0] s;
    logic [MOD_W:0] r;
    s = {1'b0, a} + {1'b0, b};
    r = (s >= {1'b0, p}) ? (s - {1'b0, p}) : s;
    return r[MOD_W-1:0];
  endfunction

  // (a - b) mod p for a, b < p
  function automatic logic [MOD_W-1:0] mod_sub(input logic [MOD_W-1:0] a,
                                               input logic [MOD_W-1:0] b,
                                               input logic [MOD_W-1:0] p);
    logic [MOD_W:0] r;
    r = (a >= b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + {1'b0, p} - {1'b0, b});
    return r[MOD_W-1:0];
  endfunction

endpackage

@@ design/fibonacci_matrix_power_mod_unit.sv @@
// Order: n mod p first, then for each bit of 2n-1 from the LSB up, a multiply into the
//   result when the bit is set followed by a squaring; then the output register is loaded.
// Throughput: one item at a time; every product goes through the single bit-serial
//   modular multiplier at one operand bit per cycle.
// A finished result waits in the output register while the next item is taken.
// Reset (async, active low) empties the block and loads the modulus with 1000000007.
`timescale 1ns / 1ps

module fibonacci_matrix_power_mod_unit #(
  parameter int unsigned EXP_WIDTH = 63
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fmpm_pkg::MOD_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [fmpm_pkg::IDX_W-1:0]   query_index_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [fmpm_pkg::MOD_W-1:0]   fib_even_o,
  output logic [fmpm_pkg::MOD_W-1:0]   answer_o
);
  import fmpm_pkg::*;

  logic [MOD_W-1:0] modulus_q;
  logic [MOD_W-1:0] p_eff;
  logic             seq_ready;
  logic             res_valid;
  logic             res_take;
  logic             in_xfer;
  fmpm_res_t        res;
  fmpm_mul_req_t    mul_req;
  fmpm_mul_rsp_t    mul_rsp;
  logic             out_valid_q;
  logic [MOD_W-1:0] fib_q;
  logic [MOD_W-1:0] ans_q;

  // modulus of 0 or 1 acts as 1
  assign p_eff = (modulus_q < MOD_W'(2)) ? MOD_W'(1) : modulus_q;

  assign in_stall_o = !seq_ready;
  assign in_xfer    = in_valid_i && seq_ready;
  assign res_take   = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MOD_RESET;
    end else if (cfg_we_i) begin
      modulus_q <= cfg_wdata_i;
    end
  end

  fmpm_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .p_i    (p_eff),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  fmpm_seq #(
    .EXP_WIDTH (EXP_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .p_i         (p_eff),
    .start_i     (in_xfer),
    .n_i         (query_index_i),
    .ready_o     (seq_ready),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .mul_req_o   (mul_req),
    .mul_rsp_i   (mul_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      fib_q <= res.fib;
      ans_q <= mod_sub(res.fib, res.nmod, p_eff);
    end
  end

  assign out_valid_o = out_valid_q;
  assign fib_even_o  = fib_q;
  assign answer_o    = ans_q;

endmodule

@@ design/fmpm_modmul.sv @@
// Bit-serial interleaved modular multiplier: r = opd * mult mod p,
// one operand bit per cycle, MSB first. Depends on fmpm_pkg.
`timescale 1ns / 1ps

module fmpm_modmul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [fmpm_pkg::MOD_W-1:0]   p_i,
  input  fmpm_pkg::fmpm_mul_req_t      req_i,
  output fmpm_pkg::fmpm_mul_rsp_t      rsp_o
);
  import fmpm_pkg::*;

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [IDX_W-1:0] opd_q;
  logic [MOD_W-1:0] mult_q;
  logic [MOD_W-1:0] r_q;
  logic [MOD_W-1:0] r_d;

  logic [MOD_W+1:0] t;
  logic [MOD_W+1:0] p1;
  logic [MOD_W+1:0] p2;
  logic             last;

  // 2r + bit*mult < 3p, so at most two moduli come off
  always_comb begin
    p1 = {2'b00, p_i};
    p2 = {1'b0, p_i, 1'b0};
    t  = {1'b0, r_q, 1'b0} + (opd_q[IDX_W-1] ? {2'b00, mult_q} : '0);
    if (t >= p2) begin
      r_d = t[MOD_W-1:0] - p2[MOD_W-1:0];
    end else if (t >= p1) begin
      r_d = t[MOD_W-1:0] - p1[MOD_W-1:0];
    end else begin
      r_d = t[MOD_W-1:0];
    end
  end

  assign last = (cnt_q == {{(CNT_W-1){1'b0}}, 1'b1});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.len;
      end else if (busy_q) begin
        cnt_q <= cnt_q - {{(CNT_W-1){1'b0}}, 1'b1};
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      r_q    <= '0;
      opd_q  <= req_i.opd;
      mult_q <= req_i.mult;
    end else if (busy_q) begin
      r_q   <= r_d;
      opd_q <= {opd_q[IDX_W-2:0], 1'b0};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = r_q;

endmodule

@@ design/fmpm_seq.sv @@
// Sequencer: n mod p, then square-and-multiply over the exponent bits, drives the shared
// modular multiplier and holds both matrices. Depends on fmpm_pkg.
`timescale 1ns / 1ps

module fmpm_seq #(
  parameter int unsigned EXP_WIDTH = 63
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [fmpm_pkg::MOD_W-1:0]   p_i,
  input  logic                         start_i,
  input  logic [fmpm_pkg::IDX_W-1:0]   n_i,
  output logic                         ready_o,
  output logic                         res_valid_o,
  input  logic                         res_take_i,
  output fmpm_pkg::fmpm_res_t          res_o,
  output fmpm_pkg::fmpm_mul_req_t      mul_req_o,
  input  fmpm_pkg::fmpm_mul_rsp_t      mul_rsp_i
);
  import fmpm_pkg::*;

  fmpm_state_e state_q, state_d;

  logic                 sel_acc_q;   // 1: acc = acc * base, 0: base = base * base
  logic [PIDX_W-1:0]    pidx_q;
  logic [IDX_W-1:0]     n_q;
  logic [EXP_WIDTH-1:0] e_q;
  logic [MOD_W-1:0]     nmod_q;
  fmpm_mat_t            acc_q;
  fmpm_mat_t            base_q;
  logic [MOD_W-1:0]     prod_q [PROD_NUM];

  logic [MOD_W-1:0]     one;
  logic [IDX_W:0]       dbl;
  logic [EXP_WIDTH-1:0] e_init;
  fmpm_mat_t            lhs_m;
  logic [MOD_W-1:0]     lhs;
  logic [MOD_W-1:0]     rhs;
  logic [MOD_W-1:0]     sum_a;
  logic [MOD_W-1:0]     sum_b;
  logic [MOD_W-1:0]     diff_c;
  logic                 last_prod;

  assign one    = (p_i == {{(MOD_W-1){1'b0}}, 1'b1}) ? '0 : {{(MOD_W-1){1'b0}}, 1'b1};
  assign dbl    = {n_i, 1'b0} - {{IDX_W{1'b0}}, 1'b1};
  assign e_init = dbl[EXP_WIDTH-1:0];

  assign lhs_m     = sel_acc_q ? acc_q : base_q;
  assign last_prod = (pidx_q == PIDX_W'(PROD_NUM - 1));

  // New entries: a = Xa*Ya + Xb*Yb, b = Xa*Yb + Xb*Yc, c = a - b
  always_comb begin
    case (pidx_q)
      2'd0:    begin lhs = lhs_m.a; rhs = base_q.a; end
      2'd1:    begin lhs = lhs_m.b; rhs = base_q.b; end
      2'd2:    begin lhs = lhs_m.a; rhs = base_q.b; end
      default: begin lhs = lhs_m.b; rhs = base_q.c; end
    endcase
  end

  assign sum_a  = mod_add(prod_q[0], prod_q[1], p_i);
  assign sum_b  = mod_add(prod_q[2], prod_q[3], p_i);
  assign diff_c = mod_sub(lhs_m.a, lhs_m.b, p_i);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:      if (start_i) state_d = S_NMOD_GO;
      S_NMOD_GO:   state_d = S_NMOD_WAIT;
      S_NMOD_WAIT: if (mul_rsp_i.done) state_d = S_BIT;
      S_BIT:       state_d = (e_q == '0) ? S_DONE : S_MUL_GO;
      S_MUL_GO:    state_d = S_MUL_WAIT;
      S_MUL_WAIT: begin
        if (mul_rsp_i.done) begin
          state_d = last_prod ? S_ADD_A : S_MUL_GO;
        end
      end
      S_ADD_A:     state_d = S_ADD_B;
      S_ADD_B:     state_d = S_SUB_C;
      S_SUB_C:     state_d = sel_acc_q ? S_MUL_GO : S_BIT;
      S_DONE:      if (res_take_i) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    mul_req_o   = '0;
    ready_o     = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: ready_o = 1'b1;
      S_NMOD_GO: begin
        mul_req_o.start = 1'b1;
        mul_req_o.opd   = n_q;
        mul_req_o.len   = CNT_W'(IDX_W);
        mul_req_o.mult  = one;
      end
      S_MUL_GO: begin
        mul_req_o.start = 1'b1;
        mul_req_o.opd   = {lhs, {(IDX_W-MOD_W){1'b0}}};
        mul_req_o.len   = CNT_W'(MOD_W);
        mul_req_o.mult  = rhs;
      end
      S_DONE: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign res_o.fib  = acc_q.a;
  assign res_o.nmod = nmod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      sel_acc_q <= 1'b0;
      pidx_q    <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_BIT: begin
          sel_acc_q <= e_q[0];
          pidx_q    <= '0;
        end
        S_MUL_WAIT: if (mul_rsp_i.done) pidx_q <= pidx_q + PIDX_W'(1);
        S_SUB_C: begin
          sel_acc_q <= 1'b0;
          pidx_q    <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          n_q    <= n_i;
          e_q    <= e_init;
          acc_q  <= {one, {MOD_W{1'b0}}, one};
          base_q <= {one, one, {MOD_W{1'b0}}};
        end
      end
      S_NMOD_WAIT: if (mul_rsp_i.done) nmod_q <= mul_rsp_i.prod;
      S_MUL_WAIT:  if (mul_rsp_i.done) prod_q[pidx_q] <= mul_rsp_i.prod;
      S_ADD_A: begin
        if (sel_acc_q) acc_q.a <= sum_a;
        else           base_q.a <= sum_a;
      end
      S_ADD_B: begin
        if (sel_acc_q) acc_q.b <= sum_b;
        else           base_q.b <= sum_b;
      end
      S_SUB_C: begin
        if (sel_acc_q) begin
          acc_q.c <= diff_c;
        end else begin
          base_q.c <= diff_c;
          e_q      <= e_q >> 1;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ design/fmpm_checker.sv @@
// Port-level checks for fibonacci_matrix_power_mod_unit, bound to the top level.
// Depends on fmpm_pkg.
`timescale 1ns / 1ps

module fmpm_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [fmpm_pkg::MOD_W-1:0]   fib_even_i,
  input  logic [fmpm_pkg::MOD_W-1:0]   answer_i
);
  import fmpm_pkg::*;

  // a transfer in starts a long computation, so the input stalls next cycle
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i |=> in_stall_i)
    else $error("input not stalled after transfer");

  // a new result only arrives from a running computation
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_stall_i))
    else $error("result appeared while idle");

  // residues stay below a modulus that is at most 2^30 - 1
  a_residue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (fib_even_i != '1) && (answer_i != '1))
    else $error("residue out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(fib_even_i) && $stable(answer_i))
    else $error("stalled result changed");

endmodule

bind fibonacci_matrix_power_mod_unit fmpm_checker u_fmpm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .fib_even_i  (fib_even_o),
  .answer_i    (answer_o)
);
